// ===== rtl/core/bad_pkg.sv =====
// shared types, constants and helpers of the box average downsampler
// no dependencies
package bad_pkg;

  localparam int unsigned MAX_OUT_WIDTH = 1024;
  localparam int unsigned MAX_IN_DIM    = 4096;
  localparam int unsigned MAX_FACTOR    = 64;

  localparam int unsigned DIM_W   = $clog2(MAX_IN_DIM) + 1;
  localparam int unsigned POS_W   = $clog2(MAX_IN_DIM);
  localparam int unsigned XADDR_W = $clog2(MAX_OUT_WIDTH);
  localparam int unsigned FAC_W   = $clog2(MAX_FACTOR) + 1;
  localparam int unsigned SUM_W   = 8 + 2 * $clog2(MAX_FACTOR);
  localparam int unsigned AREA_W  = 2 * $clog2(MAX_FACTOR) + 1;
  localparam int unsigned ROW_W   = 3 * SUM_W;

  localparam logic [12:0] RST_IN_WIDTH   = 13'd512;
  localparam logic [12:0] RST_IN_HEIGHT  = 13'd512;
  localparam logic [10:0] RST_OUT_WIDTH  = 11'd64;
  localparam logic [12:0] RST_OUT_HEIGHT = 13'd64;
  localparam logic [1:0]  RST_FORMAT     = 2'd1;
  localparam logic [FAC_W-1:0] RST_FACTOR = FAC_W'(512 / 64);

  // configuration register indexes
  localparam logic [2:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_FORMAT     = 3'd4;

  localparam logic [1:0] FMT_LUMA = 2'd0;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } pix_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        frame_done;
  } res_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/core/bad_if.sv =====
// handshake channels of the box average downsampler
// depends on bad_pkg
interface bad_pix_if;
  logic valid;
  logic ready;
  bad_pkg::pix_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bad_res_if;
  logic valid;
  logic ready;
  bad_pkg::res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bad_cfg_if;
  logic valid;
  logic ready;
  bad_pkg::cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/bad_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/core/bad_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on bad_pkg
module bad_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bad_pkg::SUM_W-1:0]     dividend_i,
  input  logic [bad_pkg::DIM_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [bad_pkg::SUM_W-1:0]     quotient_o
);
  localparam int unsigned CNT_W = $clog2(bad_pkg::SUM_W + 1);

  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q;
  logic [bad_pkg::DIM_W-1:0]     rem_q;
  logic [bad_pkg::DIM_W-1:0]     dvs_q;
  logic [bad_pkg::SUM_W-1:0]     quo_q;
  logic [bad_pkg::DIM_W:0]       shifted;
  logic                          fits;

  assign shifted = {rem_q, quo_q[bad_pkg::SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_o <= 1'b0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      // pulse on the last quotient bit
      done_o <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(bad_pkg::SUM_W);
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? bad_pkg::DIM_W'(shifted - {1'b0, dvs_q})
                      : shifted[bad_pkg::DIM_W-1:0];
        quo_q <= {quo_q[bad_pkg::SUM_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign quotient_o = quo_q;
endmodule

// ===== rtl/core/box_average_image_downsampler.sv =====
// box average image downsampler, top level
// depends on bad_pkg, bad_if, bad_ram and bad_div
//
// Takes one pixel per transfer in raster order and sums each factor_x by
// factor_y block per channel in a 1024-entry column accumulator ram (60 bits
// an entry: blue, green, red sums). Factors are the integer ratios of input to
// output size, saturated at 64, and are worked out when a pixel marked
// frame_start arrives (two divisions on the shared divider before that pixel
// goes on). A pixel goes from the transfer to issuing the accumulator read
// and then to the read-modify-write before it is ready again; a pixel outside
// a whole block skips the read and the write. The pixel that closes a block
// then runs three divisions by the block area on the shared divider and loads
// the output register, and its result goes to an output register that the
// next pixel does not wait on unless a second result is due.
// Output rows count bottom-up, luminance fills all three channels and alpha is
// dropped. Columns and rows past the last whole block give no result. There
// is no clearing pass: the first pixel of a block writes its accumulator
// without adding the value that was read.
module box_average_image_downsampler (
  input  logic      clk_i,
  input  logic      rst_ni,
  bad_pix_if.sink   pix_i,
  bad_res_if.source res_o,
  bad_cfg_if.sink   cfg_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_FX, S_FY, S_POS, S_ACC, S_DIV, S_EMIT
  } state_e;

  localparam int unsigned DIM_W = bad_pkg::DIM_W;
  localparam int unsigned POS_W = bad_pkg::POS_W;
  localparam int unsigned FAC_W = bad_pkg::FAC_W;
  localparam int unsigned SUM_W = bad_pkg::SUM_W;
  localparam logic [1:0]  LAST_CH = 2'd2;

  state_e state_q;

  // configuration registers
  logic [12:0] in_width_q, in_height_q, out_height_q;
  logic [10:0] out_width_q;
  logic [1:0]  format_q;

  // effective sizes
  logic [DIM_W-1:0] eff_iw, eff_ih, eff_ow, eff_oh, ow_hi;

  // position and block counters
  logic [POS_W-1:0] col_q, row_q, bx_q, by_q;
  logic [FAC_W-1:0] ix_q, iy_q, fx_q, fy_q;
  logic [bad_pkg::AREA_W-1:0] area_q;

  logic [POS_W-1:0] col_n, row_n, bx_n, by_n;
  logic [FAC_W-1:0] ix_n, iy_n;

  // latched pixel
  logic [7:0] r_q, g_q, b_q;

  // accumulation
  logic active, first, last;
  logic [bad_pkg::ROW_W-1:0] rdata, new_sum, sum_q;
  logic [SUM_W-1:0] add_b, add_g, add_r;

  // divider hookup
  logic              div_start_q, div_done;
  logic [SUM_W-1:0]  div_dvd_q, div_quo;
  logic [DIM_W-1:0]  div_dvs_q;
  logic [FAC_W-1:0]  fac_clamped;
  logic [1:0]        ch_q;
  logic [23:0]       avg_q;

  // result
  bad_pkg::res_t res_q;
  logic          res_vld_q;
  logic [9:0]    oc_q;
  logic [11:0]   or_q;
  logic          done_q;

  logic pix_xfer, res_xfer, emit;

  assign pix_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;
  assign pix_xfer    = pix_i.valid && pix_i.ready;
  assign res_xfer    = res_o.valid && res_o.ready;
  // output register free or emptied in this cycle
  assign emit        = (state_q == S_EMIT) && (!res_vld_q || res_o.ready);

  // sizes are read live
  always_comb begin
    eff_iw = bad_pkg::clamp_dim(in_width_q, DIM_W'(bad_pkg::MAX_IN_DIM));
    eff_ih = bad_pkg::clamp_dim(in_height_q, DIM_W'(bad_pkg::MAX_IN_DIM));
    ow_hi  = (eff_iw < DIM_W'(bad_pkg::MAX_OUT_WIDTH)) ? eff_iw
                                                       : DIM_W'(bad_pkg::MAX_OUT_WIDTH);
    eff_ow = bad_pkg::clamp_dim(DIM_W'(out_width_q), ow_hi);
    eff_oh = bad_pkg::clamp_dim(out_height_q, eff_ih);
  end

  // pixel position stepping, block indexes tracked alongside
  always_comb begin
    col_n = col_q;
    row_n = row_q;
    ix_n  = ix_q;
    iy_n  = iy_q;
    bx_n  = bx_q;
    by_n  = by_q;
    if ({1'b0, col_q} + DIM_W'(1) >= eff_iw) begin
      col_n = '0;
      ix_n  = '0;
      bx_n  = '0;
      if ({1'b0, row_q} + DIM_W'(1) >= eff_ih) begin
        row_n = '0;
        iy_n  = '0;
        by_n  = '0;
      end else begin
        row_n = row_q + POS_W'(1);
        if (iy_q + FAC_W'(1) == fy_q) begin
          iy_n = '0;
          by_n = by_q + POS_W'(1);
        end else begin
          iy_n = iy_q + FAC_W'(1);
        end
      end
    end else begin
      col_n = col_q + POS_W'(1);
      if (ix_q + FAC_W'(1) == fx_q) begin
        ix_n = '0;
        bx_n = bx_q + POS_W'(1);
      end else begin
        ix_n = ix_q + FAC_W'(1);
      end
    end
  end

  assign active = ({1'b0, col_q} < eff_iw) && ({1'b0, row_q} < eff_ih) &&
                  ({1'b0, bx_q} < eff_ow) && ({1'b0, by_q} < eff_oh);
  assign first  = (ix_q == '0) && (iy_q == '0);
  assign last   = (ix_q == fx_q - FAC_W'(1)) && (iy_q == fy_q - FAC_W'(1));

  // read-modify-write of one column accumulator
  assign add_b   = rdata[SUM_W-1:0]         + SUM_W'(b_q);
  assign add_g   = rdata[2*SUM_W-1:SUM_W]   + SUM_W'(g_q);
  assign add_r   = rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(r_q);
  assign new_sum = first ? {SUM_W'(r_q), SUM_W'(g_q), SUM_W'(b_q)}
                         : {add_r, add_g, add_b};

  bad_ram #(
    .WIDTH(bad_pkg::ROW_W),
    .DEPTH(bad_pkg::MAX_OUT_WIDTH)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (state_q == S_ACC),
    .waddr_i(bx_q[bad_pkg::XADDR_W-1:0]),
    .wdata_i(new_sum),
    .re_i   ((state_q == S_POS) && active),
    .raddr_i(bx_q[bad_pkg::XADDR_W-1:0]),
    .rdata_o(rdata)
  );

  bad_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd_q),
    .divisor_i (div_dvs_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // factor saturates to the supported range
  assign fac_clamped = (div_quo > SUM_W'(bad_pkg::MAX_FACTOR)) ? FAC_W'(bad_pkg::MAX_FACTOR) :
                       (div_quo == '0) ? FAC_W'(1) : div_quo[FAC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_width_q   <= bad_pkg::RST_IN_WIDTH;
      in_height_q  <= bad_pkg::RST_IN_HEIGHT;
      out_width_q  <= bad_pkg::RST_OUT_WIDTH;
      out_height_q <= bad_pkg::RST_OUT_HEIGHT;
      format_q     <= bad_pkg::RST_FORMAT;
      col_q        <= '0;
      row_q        <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      ix_q         <= '0;
      iy_q         <= '0;
      fx_q         <= bad_pkg::RST_FACTOR;
      fy_q         <= bad_pkg::RST_FACTOR;
      area_q       <= bad_pkg::AREA_W'(bad_pkg::RST_FACTOR) *
                      bad_pkg::AREA_W'(bad_pkg::RST_FACTOR);
      r_q          <= '0;
      g_q          <= '0;
      b_q          <= '0;
      sum_q        <= '0;
      div_start_q  <= 1'b0;
      div_dvd_q    <= '0;
      div_dvs_q    <= '0;
      ch_q         <= '0;
      avg_q        <= '0;
      oc_q         <= '0;
      or_q         <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      // divider kicked for the factors, then once per channel of a closed block
      div_start_q <= (state_q == S_IDLE && pix_xfer && pix_i.data.frame_start) ||
                     (state_q == S_FX && div_done) ||
                     (state_q == S_ACC && last) ||
                     (state_q == S_DIV && div_done && ch_q != LAST_CH);
      area_q      <= bad_pkg::AREA_W'(fx_q) * bad_pkg::AREA_W'(fy_q);

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          bad_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg_i.data.data;
          bad_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg_i.data.data;
          bad_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_i.data.data[10:0];
          bad_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_i.data.data;
          bad_pkg::CFG_FORMAT:     format_q     <= cfg_i.data.data[1:0];
          default: ;
        endcase
      end

      if (emit) begin
        res_vld_q <= 1'b1;
      end else if (res_xfer) begin
        res_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (pix_xfer) begin
            r_q <= pix_i.data.byte0;
            g_q <= (format_q == bad_pkg::FMT_LUMA) ? pix_i.data.byte0 : pix_i.data.byte1;
            b_q <= (format_q == bad_pkg::FMT_LUMA) ? pix_i.data.byte0 : pix_i.data.byte2;
            if (pix_i.data.frame_start) begin
              // restart the frame and work out new factors
              col_q       <= '0;
              row_q       <= '0;
              bx_q        <= '0;
              by_q        <= '0;
              ix_q        <= '0;
              iy_q        <= '0;
              div_dvd_q   <= SUM_W'(eff_iw);
              div_dvs_q   <= eff_ow;
              state_q     <= S_FX;
            end else begin
              state_q <= S_POS;
            end
          end
        end
        S_FX: begin
          if (div_done) begin
            fx_q        <= fac_clamped;
            div_dvd_q   <= SUM_W'(eff_ih);
            div_dvs_q   <= eff_oh;
            state_q     <= S_FY;
          end
        end
        S_FY: begin
          if (div_done) begin
            fy_q    <= fac_clamped;
            state_q <= S_POS;
          end
        end
        S_POS: begin
          // the ram read is issued here when the pixel lies in a whole block
          if (active) begin
            state_q <= S_ACC;
          end else begin
            col_q   <= col_n;
            row_q   <= row_n;
            ix_q    <= ix_n;
            iy_q    <= iy_n;
            bx_q    <= bx_n;
            by_q    <= by_n;
            state_q <= S_IDLE;
          end
        end
        S_ACC: begin
          col_q <= col_n;
          row_q <= row_n;
          ix_q  <= ix_n;
          iy_q  <= iy_n;
          bx_q  <= bx_n;
          by_q  <= by_n;
          if (last) begin
            sum_q       <= new_sum;
            oc_q        <= bx_q[9:0];
            or_q        <= 12'(eff_oh - DIM_W'(1) - {1'b0, by_q});
            done_q      <= ({1'b0, bx_q} == eff_ow - DIM_W'(1)) &&
                           ({1'b0, by_q} == eff_oh - DIM_W'(1));
            div_dvd_q   <= new_sum[SUM_W-1:0];
            div_dvs_q   <= DIM_W'(area_q);
            ch_q        <= '0;
            state_q     <= S_DIV;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          // blue, then green, then red
          if (div_done) begin
            avg_q <= {div_quo[7:0], avg_q[23:8]};
            if (ch_q == LAST_CH) begin
              state_q <= S_EMIT;
            end else begin
              sum_q       <= sum_q >> SUM_W;
              div_dvd_q   <= sum_q[2*SUM_W-1:SUM_W];
              ch_q        <= ch_q + 2'd1;
            end
          end
        end
        S_EMIT: begin
          if (emit) begin
            res_q.blue       <= avg_q[7:0];
            res_q.green      <= avg_q[15:8];
            res_q.red        <= avg_q[23:16];
            res_q.out_column <= oc_q;
            res_q.out_row    <= or_q;
            res_q.frame_done <= done_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/bad_chk.sv =====
// port-level checks of the box average downsampler, bound to the top level
// depends on bad_if through the bound top level
module bad_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [46:0] res_data
);
  // a pixel is worked on alone: no transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("pixel taken in the cycle after a transfer");

  // a new result only shows up while the pixel side is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(!pix_ready))
    else $error("result appeared without a pixel being processed");

  // a result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result changed while stalled");
endmodule

bind box_average_image_downsampler bad_chk u_bad_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pix_valid(pix_i.valid),
  .pix_ready(pix_i.ready),
  .res_valid(res_o.valid),
  .res_ready(res_o.ready),
  .res_data (res_o.data)
);
